>>> rtl/lsw_pkg.sv
// Shared constants and types for the lap stopwatch.
// No dependencies; used by lsw_hms and lap_stopwatch.
package lsw_pkg;

  // Configuration port
  localparam int          ADDR_W           = 3;
  localparam logic [0:0]  REG_HOLD_LIMIT   = 1'b0;
  localparam logic [15:0] HOLD_LIMIT_RESET = 16'd1000;

  // Clock arithmetic
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] HOURS_PER_DAY = 32'd24;
  // n/15 == (n * M15) >> 35 and n/3 == (n * M3) >> 33 for any 32-bit n
  localparam logic [31:0] M15    = 32'h8888_8889;
  localparam int          M15_SH = 35;
  localparam logic [31:0] M3     = 32'hAAAA_AAAB;
  localparam int          M3_SH  = 33;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

endpackage

>>> rtl/lap_stopwatch.sv
// Top level of the lap stopwatch: control state, lap memory, config port.
// Depends on lsw_pkg and lsw_hms.

// One item is one poll tick; every accepted item yields exactly one result
// item, and a new item is taken every cycle while in_stall is low. All
// button handling and the lap memory write happen at the edge the item
// is accepted, so the state seen by the next item is always current. The
// result then passes a register stage holding the lap memory read, three
// constant-reciprocal multiply stages that split the total into hours,
// minutes and seconds, and the result register, five registers in all. The
// pipeline is elastic: bubbles collapse, so input keeps flowing while a
// result waits under out_stall until every stage is full. The lap memory
// (MAX_LAPS entries of split and overall time) needs no clearing pass: only
// entries below the lap count are ever used, and they are written in order
// after every clear. hold_limit sits at byte address 0 of the APB port and
// should only be written while no items are in flight.
module lap_stopwatch #(
  parameter int MAX_LAPS      = 16,
  parameter int LAPS_PER_PAGE = 4,
  localparam int CW = $clog2(MAX_LAPS + 1),
  localparam int IW = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                now_seconds,
  input  logic                       start_edge,
  input  logic                       lap_edge,
  input  logic                       lap_held,
  input  logic [15:0]                held_duration,
  input  logic                       page_edge,
  input  logic [3:0]                 lap_back,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                total_time,
  output logic [4:0]                 hours,
  output logic [5:0]                 minutes,
  output logic [5:0]                 seconds,
  output logic                       is_running,
  output logic                       is_cleared,
  output logic                       show_overall,
  output logic [CW-1:0]              lap_count,
  output logic [CW-1:0]              page_count,
  output logic [IW-1:0]              current_page,
  output logic [31:0]                lap_value,
  output logic                       lap_valid
);

  localparam int PW     = (LAPS_PER_PAGE > 1) ? $clog2(LAPS_PER_PAGE) : 1;
  localparam int BW     = (CW > 4) ? CW + 1 : 5;
  localparam int SIDE_W = 3 + CW + CW + IW + 32 + 1;

  // ---------------- configuration ----------------
  logic [15:0] hold_limit;
  logic        reg_sel;

  assign reg_sel = (paddr[lsw_pkg::ADDR_W-1:2] == lsw_pkg::REG_HOLD_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'b0, hold_limit} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit <= lsw_pkg::HOLD_LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      hold_limit <= pwdata[15:0];
    end
  end

  // ---------------- timing state ----------------
  logic [31:0]   start_mark, run_span, paused_sum, prev_total;
  logic          running, cleared, overall_view;
  logic [CW-1:0] laps, pages;
  logic [IW-1:0] page_now;
  logic [PW-1:0] page_fill;   // (laps-2) mod LAPS_PER_PAGE

  logic [31:0]   start_mark_next, run_span_next, paused_sum_next, prev_total_next;
  logic          running_next, cleared_next, overall_view_next;
  logic [CW-1:0] laps_next, pages_next, laps_inc;
  logic [IW-1:0] page_next;
  logic [PW-1:0] page_fill_next;
  logic [PW:0]   fill_inc;
  logic [31:0]   total_c;
  logic          wr_en;
  logic [63:0]   wr_word;      // {split, overall}
  logic [BW-1:0] idx_full;
  logic [IW-1:0] rd_idx;
  logic          lvalid_c;
  logic          accept;

  // stage 1
  logic          s1_v;
  logic [31:0]   s1_total;
  logic          s1_run, s1_clr, s1_view, s1_lvalid;
  logic [CW-1:0] s1_laps, s1_pages;
  logic [IW-1:0] s1_page;
  logic [63:0]   rd_word, byp_word;
  logic          byp;
  logic [63:0]   lap_word;
  logic [31:0]   lap_sel;
  logic          hms_ready;

  logic [63:0] lap_mem [MAX_LAPS];

  assign in_stall = s1_v && !hms_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    start_mark_next   = start_mark;
    run_span_next     = run_span;
    paused_sum_next   = paused_sum;
    prev_total_next   = prev_total;
    running_next      = running;
    cleared_next      = cleared;
    overall_view_next = overall_view;
    laps_next         = laps;
    pages_next        = pages;
    page_next         = page_now;
    page_fill_next    = page_fill;
    wr_en             = 1'b0;
    laps_inc          = laps + CW'(1);
    fill_inc          = {1'b0, page_fill} + (PW + 1)'(1);

    // start / pause / continue
    if (start_edge) begin
      if (running) begin
        running_next = 1'b0;
      end else begin
        if (!cleared) paused_sum_next = paused_sum + run_span;
        start_mark_next = now_seconds;
        cleared_next    = 1'b0;
        running_next    = 1'b1;
      end
    end

    if (running_next) run_span_next = now_seconds - start_mark_next;
    total_c = run_span_next + paused_sum_next;
    wr_word = {total_c - prev_total, total_c};

    if (running_next) begin
      if (lap_edge && (laps < CW'(MAX_LAPS))) begin
        wr_en           = 1'b1;
        laps_next       = laps_inc;
        prev_total_next = total_c;
        if (laps_inc <= CW'(2)) begin
          pages_next     = CW'(1);
          page_fill_next = '0;
        end else if (fill_inc == (PW + 1)'(LAPS_PER_PAGE)) begin
          page_fill_next = '0;
          pages_next     = pages + CW'(1);
        end else begin
          page_fill_next = fill_inc[PW-1:0];
        end
      end
    end else begin
      if (lap_edge) overall_view_next = !overall_view;
      if (lap_held && (held_duration > hold_limit)) begin
        run_span_next   = '0;
        paused_sum_next = '0;
        prev_total_next = '0;
        laps_next       = '0;
        pages_next      = '0;
        page_next       = '0;
        page_fill_next  = '0;
        cleared_next    = 1'b1;
        total_c         = '0;
      end
    end

    // page cycling; page_now stays below pages whenever pages is nonzero
    if (page_edge && (pages_next > CW'(1))) begin
      if ((CW'(page_next) + CW'(1)) == pages_next) page_next = '0;
      else page_next = page_next + IW'(1);
    end

    // readback address, counted back from the newest lap
    lvalid_c = BW'(lap_back) < BW'(laps_next);
    idx_full = BW'(laps_next) - BW'(1) - BW'(lap_back);
    rd_idx   = idx_full[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark   <= '0;
      run_span     <= '0;
      paused_sum   <= '0;
      prev_total   <= '0;
      running      <= 1'b0;
      cleared      <= 1'b1;
      overall_view <= 1'b1;
      laps         <= '0;
      pages        <= '0;
      page_now     <= '0;
      page_fill    <= '0;
      s1_v         <= 1'b0;
    end else begin
      if (accept) begin
        start_mark   <= start_mark_next;
        run_span     <= run_span_next;
        paused_sum   <= paused_sum_next;
        prev_total   <= prev_total_next;
        running      <= running_next;
        cleared      <= cleared_next;
        overall_view <= overall_view_next;
        laps         <= laps_next;
        pages        <= pages_next;
        page_now     <= page_next;
        page_fill    <= page_fill_next;
      end
      if (!s1_v || hms_ready) s1_v <= in_valid;
    end
  end

  // lap memory: write at the lap count, registered read with write bypass
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en) lap_mem[laps[IW-1:0]] <= wr_word;
      rd_word   <= lap_mem[rd_idx];
      byp       <= wr_en && (laps[IW-1:0] == rd_idx);
      byp_word  <= wr_word;
      s1_total  <= total_c;
      s1_run    <= running_next;
      s1_clr    <= cleared_next;
      s1_view   <= overall_view_next;
      s1_laps   <= laps_next;
      s1_pages  <= pages_next;
      s1_page   <= page_next;
      s1_lvalid <= lvalid_c;
    end
  end

  assign lap_word = byp ? byp_word : rd_word;
  assign lap_sel  = !s1_lvalid ? 32'b0 : (s1_view ? lap_word[31:0] : lap_word[63:32]);

  // ---------------- h/m/s split and result register ----------------
  logic [SIDE_W-1:0] side_in, side_out;
  lsw_pkg::hms_t     hms;

  assign side_in = {s1_run, s1_clr, s1_view, s1_laps, s1_pages, s1_page,
                    lap_sel, s1_lvalid};

  lsw_hms #(
    .SIDE_W (SIDE_W)
  ) u_hms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_v),
    .in_ready  (hms_ready),
    .in_total  (s1_total),
    .in_side   (side_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_total (total_time),
    .out_hms   (hms),
    .out_side  (side_out)
  );

  assign {is_running, is_cleared, show_overall, lap_count, page_count,
          current_page, lap_value, lap_valid} = side_out;
  assign hours   = hms.hours;
  assign minutes = hms.minutes;
  assign seconds = hms.seconds;

endmodule

>>> rtl/lsw_hms.sv
// Elastic pipeline splitting a 32-bit seconds count into h/m/s.
// Depends on lsw_pkg. Side data travels along unchanged.
module lsw_hms #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_total,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_total,
  output lsw_pkg::hms_t     out_hms,
  output logic [SIDE_W-1:0] out_side
);

  localparam int M15_SH = lsw_pkg::M15_SH;
  localparam int M3_SH  = lsw_pkg::M3_SH;

  // stage a: total/60 product
  logic              a_v;
  logic [31:0]       a_total;
  logic [SIDE_W-1:0] a_side;
  logic [61:0]       a_prod;
  // stage b: seconds, q60/60 product
  logic              b_v;
  logic [31:0]       b_total;
  logic [SIDE_W-1:0] b_side;
  logic [26:0]       b_q60;
  logic [5:0]        b_sec;
  logic [56:0]       b_prod;
  // stage c: minutes, hours/24 product
  logic              c_v;
  logic [31:0]       c_total;
  logic [SIDE_W-1:0] c_side;
  logic [5:0]        c_sec;
  logic [5:0]        c_min;
  logic [21:0]       c_q3600;
  logic [50:0]       c_prod;
  // stage d: result register
  logic              d_v;

  logic a_rdy, b_rdy, c_rdy, d_rdy;
  logic [26:0] q60;
  logic [21:0] q3600;
  logic [17:0] q24;
  logic [31:0] sec_full, min_full, hr_full;

  assign d_rdy    = !d_v || !out_stall;
  assign c_rdy    = !c_v || d_rdy;
  assign b_rdy    = !b_v || c_rdy;
  assign a_rdy    = !a_v || b_rdy;
  assign in_ready = a_rdy;

  assign q60      = a_prod[61:M15_SH];
  assign sec_full = a_total - 32'(q60) * lsw_pkg::SECS_PER_MIN;
  assign q3600    = b_prod[56:M15_SH];
  assign min_full = 32'(b_q60) - 32'(q3600) * lsw_pkg::SECS_PER_MIN;
  assign q24      = c_prod[50:M3_SH];
  assign hr_full  = 32'(c_q3600) - 32'(q24) * lsw_pkg::HOURS_PER_DAY;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (a_rdy) a_v <= in_valid;
      if (b_rdy) b_v <= a_v;
      if (c_rdy) c_v <= b_v;
      if (d_rdy) d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_total <= in_total;
      a_side  <= in_side;
      a_prod  <= 62'(in_total[31:2]) * 62'(lsw_pkg::M15);
    end
    if (b_rdy && a_v) begin
      b_total <= a_total;
      b_side  <= a_side;
      b_q60   <= q60;
      b_sec   <= sec_full[5:0];
      b_prod  <= 57'(q60[26:2]) * 57'(lsw_pkg::M15);
    end
    if (c_rdy && b_v) begin
      c_total <= b_total;
      c_side  <= b_side;
      c_sec   <= b_sec;
      c_min   <= min_full[5:0];
      c_q3600 <= q3600;
      c_prod  <= 51'(q3600[21:3]) * 51'(lsw_pkg::M3);
    end
    if (d_rdy && c_v) begin
      out_total       <= c_total;
      out_side        <= c_side;
      out_hms.seconds <= c_sec;
      out_hms.minutes <= c_min;
      out_hms.hours   <= hr_full[4:0];
    end
  end

  assign out_valid = d_v;

endmodule
